>>> hw/rtl/tbd_pkg.sv
// Package: constants, command and state codes, controller command struct for the decryptor.
`default_nettype none

package tbd_pkg;

    localparam int ROUNDS      = 17;
    localparam int KEY_COUNT   = 101;
    localparam int BANKS       = 16;
    localparam int BANK_WORDS  = 256;
    localparam int WORD_W      = 32;
    localparam int BLOCK_W     = 128;

    localparam int TABLE_DEPTH = ROUNDS * BANKS * BANK_WORDS;
    localparam int KEY_DEPTH   = KEY_COUNT * ROUNDS * 4;
    localparam int BANK_DEPTH  = ROUNDS * BANK_WORDS;
    localparam int KEY_ROWS    = KEY_COUNT * ROUNDS;

    localparam int ROUND_W     = $clog2(ROUNDS);
    localparam int BANK_AW     = $clog2(BANK_DEPTH);
    localparam int KEY_AW      = $clog2(KEY_ROWS);
    localparam int KEY_W       = 7;
    localparam int ADDR_W      = 17;
    localparam int CMD_W       = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD_TABLE = 2'd0,
        CMD_LOAD_KEY   = 2'd1,
        CMD_DECRYPT    = 2'd2
    } tbd_cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_ROUND,
        ST_DONE
    } tbd_state_t;

    // controller -> datapath
    typedef struct packed {
        logic               capture;     // latch block and key
        logic               issue_first; // read addresses from held block
        logic               step;        // fold read data into block
        logic               load_out;    // copy block to output register
        logic               wr_table;
        logic               wr_key;
        logic [ROUND_W-1:0] rd_round;    // round being read
        logic [ROUND_W-1:0] cur_round;   // round whose data is returning
    } tbd_ctl_t;

endpackage

`default_nettype wire

>>> hw/rtl/tbd_ram.sv
// Generic simple dual-port RAM, one write port and one registered read port.
`default_nettype none

module tbd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

>>> hw/rtl/tbd_ctrl.sv
// Controller: command decode, round sequencing and output handshake.
`default_nettype none

module tbd_ctrl
    import tbd_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  logic [CMD_W-1:0] in_cmd,
    output logic            in_ready,
    output logic            out_valid,
    input  logic            out_ready,
    output tbd_ctl_t        ctl
);

    tbd_state_t         state_reg, state_next;
    logic [ROUND_W-1:0] round_reg, round_next;
    logic               out_valid_reg, out_valid_next;
    logic               accept;
    logic               last;
    logic               out_free;

    assign accept   = in_valid && (state_reg == ST_IDLE);
    assign last     = (round_reg == ROUND_W'(ROUNDS - 1));
    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && (tbd_cmd_t'(in_cmd) == CMD_DECRYPT))
                begin
                    state_next = ST_ISSUE;
                end
            end
            ST_ISSUE: state_next = ST_ROUND;
            ST_ROUND:
            begin
                if (last)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        ctl             = '0;
        in_ready        = 1'b0;
        round_next      = round_reg;
        ctl.cur_round   = round_reg;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (accept)
                begin
                    case (tbd_cmd_t'(in_cmd))
                        CMD_LOAD_TABLE: ctl.wr_table = 1'b1;
                        CMD_LOAD_KEY:   ctl.wr_key   = 1'b1;
                        CMD_DECRYPT:    ctl.capture  = 1'b1;
                        default:        ctl.capture  = 1'b0;
                    endcase
                end
            end
            ST_ISSUE:
            begin
                ctl.issue_first = 1'b1;
                round_next      = '0;
            end
            ST_ROUND:
            begin
                ctl.step = 1'b1;
                if (last)
                begin
                    round_next = '0;
                end
                else
                begin
                    ctl.rd_round = round_reg + ROUND_W'(1);
                    round_next   = round_reg + ROUND_W'(1);
                end
            end
            ST_DONE:
            begin
                ctl.load_out = out_free;
            end
            default: ctl = '0;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (ctl.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            round_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            round_reg     <= round_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

>>> hw/rtl/tbd_datapath.sv
// Datapath: table and subkey banks, round XOR network, block and output registers.
`default_nettype none

module tbd_datapath
    import tbd_pkg::*;
(
    input  logic               clk,
    input  tbd_ctl_t           ctl,
    input  logic [ADDR_W-1:0]  load_addr,
    input  logic [WORD_W-1:0]  load_word,
    input  logic [KEY_W-1:0]   key_select,
    input  logic [BLOCK_W-1:0] cipher,
    output logic [BLOCK_W-1:0] plain
);

    logic [BLOCK_W-1:0]            block_reg, block_next;
    logic [BLOCK_W-1:0]            out_reg;
    logic [KEY_AW-1:0]             key_base_reg;
    logic [KEY_W-1:0]              key_mod;
    logic [BLOCK_W-1:0]            round_out;
    logic [BLOCK_W-1:0]            rd_block;
    logic [BANKS-1:0][WORD_W-1:0]  tbl_rdata;
    logic [3:0][WORD_W-1:0]        key_rdata;
    logic                          tbl_in_range;
    logic                          key_in_range;
    logic                          straight;
    logic [BANK_AW-1:0]            tbl_waddr;
    logic [KEY_AW-1:0]             key_raddr;

    // one subtract suffices while the select stays below twice the key count
    assign key_mod = (key_select >= KEY_W'(KEY_COUNT)) ?
                     (key_select - KEY_W'(KEY_COUNT)) : key_select;

    assign tbl_in_range = (load_addr < ADDR_W'(TABLE_DEPTH));
    assign key_in_range = (load_addr < ADDR_W'(KEY_DEPTH));
    // bank row = round * 256 + byte
    assign tbl_waddr    = {load_addr[ADDR_W-1:12], load_addr[7:0]};
    assign key_raddr    = key_base_reg + KEY_AW'(ctl.rd_round);

    always_comb
    begin
        straight = 1'b0;
        if (ctl.cur_round inside {ROUND_W'(0), ROUND_W'(1), ROUND_W'(ROUNDS - 1)})
        begin
            straight = 1'b1;
        end
    end

    // each bank p sees byte p; the grouping only picks which lookups meet
    always_comb
    begin
        logic [WORD_W-1:0] acc;
        logic [3:0]        pos;
        round_out = '0;
        for (int i = 0; i < 4; i++)
        begin
            acc = key_rdata[i];
            for (int j = 0; j < 4; j++)
            begin
                if (straight)
                begin
                    pos = 4'(4 * i + j);
                end
                else
                begin
                    pos = 4'(4 * j + ((i - j) & 3));
                end
                acc = acc ^ tbl_rdata[pos];
            end
            round_out[WORD_W*i +: WORD_W] = acc;
        end
    end

    assign rd_block = ctl.issue_first ? block_reg : round_out;

    genvar p;
    generate
        for (p = 0; p < BANKS; p++)
        begin : g_tbl
            tbd_ram #(
                .WIDTH (WORD_W),
                .DEPTH (BANK_DEPTH)
            ) u_bank (
                .clk   (clk),
                .we    (ctl.wr_table && tbl_in_range && (load_addr[11:8] == 4'(p))),
                .waddr (tbl_waddr),
                .wdata (load_word),
                .raddr ({ctl.rd_round, rd_block[8*p +: 8]}),
                .rdata (tbl_rdata[p])
            );
        end
        for (p = 0; p < 4; p++)
        begin : g_key
            tbd_ram #(
                .WIDTH (WORD_W),
                .DEPTH (KEY_ROWS)
            ) u_subkey (
                .clk   (clk),
                .we    (ctl.wr_key && key_in_range && (load_addr[1:0] == 2'(p))),
                .waddr (load_addr[KEY_AW+1:2]),
                .wdata (load_word),
                .raddr (key_raddr),
                .rdata (key_rdata[p])
            );
        end
    endgenerate

    always_comb
    begin
        block_next = block_reg;
        if (ctl.capture)
        begin
            block_next = cipher;
        end
        else if (ctl.step)
        begin
            block_next = round_out;
        end
    end

    always_ff @(posedge clk)
    begin
        block_reg <= block_next;
        if (ctl.capture)
        begin
            key_base_reg <= KEY_AW'(key_mod) * KEY_AW'(ROUNDS);
        end
        if (ctl.load_out)
        begin
            out_reg <= block_reg;
        end
    end

    assign plain = out_reg;

endmodule

`default_nettype wire

>>> hw/rtl/table_round_block_decrypt.sv
// Top level of the 17-round table block decryptor.
//
// Use:
//   One input stream carries commands. tuser holds the command: load a table
//   word, load a subkey word, or decrypt a 16-byte block. Loads write one
//   32-bit word into the table banks (17 rounds x 16 positions x 256 words)
//   or the subkey store (101 keys x 17 rounds x 4 words); addresses past a
//   store's end are dropped. Load words are taken back to back.
//   A decrypt word returns one plain block on the output stream.
// Sequence:
//   A decrypt is accepted, then an issue state starts the round 0 reads, then
//   the round state folds the 17 rounds in turn (16 table banks plus 4 subkey
//   banks read in parallel, registered read), then a done state moves the block
//   into the output register once it is free and the controller returns to
//   idle. No new word is taken before then; the round loop through the
//   registered bank reads sets the pace.
// Reset:
//   rst_n clears the sequencer and the output valid; store contents are
//   undefined until loaded and need no clearing pass.
// Stall:
//   A waiting result holds in the output register; new words are taken
//   meanwhile, but a second finished block waits until the first is taken.
`default_nettype none

module table_round_block_decrypt
    import tbd_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // load_addr[16:0], load_word[48:17], key_select[55:49],
    // cipher_lo[119:56], cipher_hi[183:120]
    input  logic [183:0] s_tdata,
    // cmd[1:0]
    input  logic [1:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // plain_lo[63:0], plain_hi[127:64]
    output logic [127:0] m_tdata
);

    tbd_ctl_t ctl;

    tbd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_cmd    (s_tuser),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .ctl       (ctl)
    );

    tbd_datapath u_dp (
        .clk        (clk),
        .ctl        (ctl),
        .load_addr  (s_tdata[16:0]),
        .load_word  (s_tdata[48:17]),
        .key_select (s_tdata[55:49]),
        .cipher     (s_tdata[183:56]),
        .plain      (m_tdata)
    );

endmodule

`default_nettype wire

>>> hw/rtl/tbd_checker.sv
// Port-level checker for the decryptor, bound to the top level.
`default_nettype none

module tbd_checker
    import tbd_pkg::*;
(
    input logic         clk,
    input logic         rst_n,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic [1:0]   s_tuser,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [127:0] m_tdata
);

    logic dec_acc;
    logic load_acc;

    assign dec_acc  = s_tvalid && s_tready && (s_tuser == CMD_DECRYPT);
    assign load_acc = s_tvalid && s_tready && (s_tuser != CMD_DECRYPT);

    // held result stays put
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // block runs its rounds without taking more words
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        dec_acc |=> !s_tready ##16 !s_tready)
        else $error("word taken during rounds");

    // loads never stall the input
    a_load: assert property (@(posedge clk) disable iff (!rst_n)
        load_acc |=> s_tready)
        else $error("load stalled input");

    // no result appears before the rounds can finish
    a_early: assert property (@(posedge clk) disable iff (!rst_n)
        dec_acc && !m_tvalid |=> !m_tvalid ##17 !m_tvalid)
        else $error("result too early");

endmodule

bind table_round_block_decrypt tbd_checker u_tbd_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
